@@ rtl/sle_pkg.sv @@
// Shared types and constants of the serial line editor.
package sle_pkg;

   // Line buffer size seen by the consumer; one place is kept for the terminator.
   localparam int LINE_CAPACITY = 128;

   // Character codes.
   localparam logic [7:0] CH_BS     = 8'h08;
   localparam logic [7:0] CH_DEL    = 8'h7F;
   localparam logic [7:0] CH_CR     = 8'h0D;
   localparam logic [7:0] CH_LF     = 8'h0A;
   localparam logic [7:0] CH_SP     = 8'h20;
   localparam logic [7:0] CH_BEL    = 8'h07;
   localparam logic [7:0] CH_PROMPT = 8'h3E;

   // Reset value of the line length register.
   localparam logic [6:0] MAX_LENGTH_RESET = 7'd79;

   // Hard cap on the line limit, derived from the buffer size.
   localparam int LIMIT_CAP_INT = (LINE_CAPACITY - 1 > 127) ? 127 : (LINE_CAPACITY - 1);
   localparam logic [6:0] LIMIT_CAP = 7'(LIMIT_CAP_INT);

   // Depth of the command queue between front and back.
   localparam int CMD_DEPTH = 2;
   localparam int CMD_PTR_W = 1;

   // Input word of one receive poll.
   typedef struct packed {
      logic       byte_present;
      logic [7:0] rx_byte;
   } req_type;

   // Output word: one transmit byte with its side information.
   typedef struct packed {
      logic [7:0] tx_byte;
      logic       last;
      logic       store_valid;
      logic [6:0] store_index;
      logic       line_done;
      logic [6:0] line_length;
   } rsp_type;

   // Action classified by the front part.
   typedef enum logic [2:0] {
      ACT_NONE,
      ACT_RUBOUT,
      ACT_NEWLINE,
      ACT_ECHO,
      ACT_BELL
   } act_type;

   // Command handed from front to back.
   typedef struct packed {
      logic       prompt;
      act_type    act;
      logic [7:0] ch;
      logic [6:0] index;
      logic [6:0] length;
   } cmd_type;

endpackage

@@ rtl/sle_front.sv @@
// Front part: accepts polls, keeps the line state and classifies each byte.
module sle_front (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   output logic             full,
   input  sle_pkg::req_type req_data,
   input  logic             csr_valid,
   output logic             csr_ready,
   input  logic [6:0]       csr_data,
   input  logic             cmd_full,
   output logic             cmd_push,
   output sle_pkg::cmd_type cmd_data
);
   import sle_pkg::*;

   logic       prompt_pending_ff, prompt_pending_in;
   logic [6:0] position_ff, position_in;
   logic [6:0] max_length_ff;
   logic [6:0] limit;
   logic       accept;
   logic       is_rubout, is_cr, is_print;
   act_type    act;

   // A poll is taken whenever the command queue has room.
   assign full      = cmd_full;
   assign accept    = push && !cmd_full;
   assign csr_ready = 1'b1;

   // Effective line limit.
   assign limit = (max_length_ff > LIMIT_CAP) ? LIMIT_CAP : max_length_ff;

   // Classify the received byte.
   assign is_rubout = (req_data.rx_byte == CH_BS) || (req_data.rx_byte == CH_DEL);
   assign is_cr     = (req_data.rx_byte == CH_CR);
   assign is_print  = (req_data.rx_byte >= CH_SP) && (req_data.rx_byte < CH_DEL);

   // Choose the action and the next line state.
   always_comb begin
      act               = ACT_NONE;
      position_in       = position_ff;
      prompt_pending_in = 1'b0;
      if (req_data.byte_present) begin
         priority if (is_rubout) begin
            if (position_ff != 7'd0) begin
               act         = ACT_RUBOUT;
               position_in = position_ff - 7'd1;
            end
         end else if (is_cr) begin
            act               = ACT_NEWLINE;
            position_in       = 7'd0;
            prompt_pending_in = 1'b1;
         end else if (is_print) begin
            if (position_ff < limit) begin
               act         = ACT_ECHO;
               position_in = position_ff + 7'd1;
            end else begin
               act = ACT_BELL;
            end
         end
      end
   end

   // Command toward the back part; polls with no output send nothing.
   always_comb begin
      cmd_data.prompt = prompt_pending_ff;
      cmd_data.act    = act;
      cmd_data.ch     = req_data.rx_byte;
      cmd_data.index  = position_ff;
      cmd_data.length = position_ff;
      cmd_push        = accept && (prompt_pending_ff || (act != ACT_NONE));
   end

   // Line state and configuration register.
   always_ff @(posedge clock) begin
      if (reset) begin
         prompt_pending_ff <= 1'b1;
         position_ff       <= 7'd0;
         max_length_ff     <= MAX_LENGTH_RESET;
      end else begin
         if (accept) begin
            prompt_pending_ff <= prompt_pending_in;
            position_ff       <= position_in;
         end
         if (csr_valid) begin
            max_length_ff <= csr_data;
         end
      end
   end

endmodule

@@ rtl/sle_cmd_fifo.sv @@
// Short command queue between the front and back parts.
module sle_cmd_fifo (
   input  logic             clock,
   input  logic             reset,
   input  logic             wr_en,
   input  sle_pkg::cmd_type wr_data,
   output logic             full_out,
   input  logic             rd_en,
   output logic             rd_valid,
   output sle_pkg::cmd_type rd_data
);
   import sle_pkg::*;

   cmd_type                mem_ff [CMD_DEPTH];
   logic [CMD_PTR_W-1:0]   wr_ptr_ff, rd_ptr_ff;
   logic [CMD_PTR_W:0]     count_ff;

   assign full_out = (count_ff == (CMD_PTR_W + 1)'(CMD_DEPTH));
   assign rd_valid = (count_ff != '0);
   assign rd_data  = mem_ff[rd_ptr_ff];

   // Storage.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_ptr_ff] <= wr_data;
      end
   end

   // Pointers and fill count.
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (wr_en) begin
            wr_ptr_ff <= wr_ptr_ff + CMD_PTR_W'(1);
         end
         if (rd_en) begin
            rd_ptr_ff <= rd_ptr_ff + CMD_PTR_W'(1);
         end
         unique case ({wr_en, rd_en})
            2'b10:   count_ff <= count_ff + (CMD_PTR_W + 1)'(1);
            2'b01:   count_ff <= count_ff - (CMD_PTR_W + 1)'(1);
            default: count_ff <= count_ff;
         endcase
      end
   end

endmodule

@@ rtl/sle_back.sv @@
// Back part: expands each command into transmit words, one per cycle while the output is drained.
module sle_back (
   input  logic             clock,
   input  logic             reset,
   input  logic             cmd_valid,
   input  sle_pkg::cmd_type cmd_data,
   output logic             cmd_pop,
   output logic             empty,
   input  logic             pop,
   output sle_pkg::rsp_type rsp_data
);
   import sle_pkg::*;

   logic       rsp_valid_ff;
   rsp_type    rsp_ff;
   rsp_type    rsp_in;
   logic       prompt_sent_ff;
   logic [1:0] step_ff;
   logic       load;
   logic       in_prompt;

   assign empty    = !rsp_valid_ff;
   assign rsp_data = rsp_ff;

   // The output register takes a new word when it is free or being drained.
   assign load      = cmd_valid && (!rsp_valid_ff || pop);
   assign in_prompt = cmd_data.prompt && !prompt_sent_ff;

   // Build the current word of the command.
   always_comb begin
      rsp_in             = '0;
      if (in_prompt) begin
         rsp_in.tx_byte = CH_PROMPT;
         rsp_in.last    = (cmd_data.act == ACT_NONE);
      end else begin
         unique case (cmd_data.act)
            ACT_RUBOUT: begin
               rsp_in.tx_byte = (step_ff == 2'd1) ? CH_SP : CH_BS;
               rsp_in.last    = (step_ff == 2'd2);
            end
            ACT_NEWLINE: begin
               rsp_in.tx_byte     = (step_ff == 2'd0) ? CH_CR : CH_LF;
               rsp_in.last        = (step_ff == 2'd1);
               rsp_in.line_done   = (step_ff == 2'd1);
               rsp_in.line_length = (step_ff == 2'd1) ? cmd_data.length : 7'd0;
            end
            ACT_ECHO: begin
               rsp_in.tx_byte     = cmd_data.ch;
               rsp_in.last        = 1'b1;
               rsp_in.store_valid = 1'b1;
               rsp_in.store_index = cmd_data.index;
            end
            ACT_BELL: begin
               rsp_in.tx_byte = CH_BEL;
               rsp_in.last    = 1'b1;
            end
            default: begin
               rsp_in.last = 1'b1;
            end
         endcase
      end
   end

   // The command leaves the queue with its final word.
   assign cmd_pop = load && rsp_in.last;

   // Output payload register.
   always_ff @(posedge clock) begin
      if (load) begin
         rsp_ff <= rsp_in;
      end
   end

   // Output valid and position within the command.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff   <= 1'b0;
         prompt_sent_ff <= 1'b0;
         step_ff        <= 2'd0;
      end else begin
         if (load) begin
            rsp_valid_ff <= 1'b1;
         end else if (pop) begin
            rsp_valid_ff <= 1'b0;
         end
         if (load) begin
            if (rsp_in.last) begin
               prompt_sent_ff <= 1'b0;
               step_ff        <= 2'd0;
            end else if (in_prompt) begin
               prompt_sent_ff <= 1'b1;
            end else begin
               step_ff <= step_ff + 2'd1;
            end
         end
      end
   end

endmodule

@@ rtl/serial_line_editor.sv @@
// Top level of the serial line editor: front classifier, command queue and emitter.
// A receive poll is taken in any cycle in which full is low; it updates the line
// position and prompt state at once and hands a command to a two-entry queue.
// The emitter drains that queue and produces one transmit word per cycle while
// pop keeps the output free. A poll yields no word when idle or ignored, one for
// an echo or bell, two for a line end, three for a rubout, and one more when the
// prompt goes out first (at most three). The emitter's one-word-per-cycle
// output register sets the sustained rate. The length register may be written
// at any time over the csr channel, which is always ready.
module serial_line_editor (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   output logic             full,
   input  sle_pkg::req_type req_data,
   output logic             empty,
   input  logic             pop,
   output sle_pkg::rsp_type rsp_data,
   input  logic             csr_valid,
   output logic             csr_ready,
   input  logic [6:0]       csr_data
);
   import sle_pkg::*;

   logic    cmd_push, cmd_full, cmd_pop, cmd_valid;
   cmd_type cmd_wr, cmd_rd;

   // Front part.
   sle_front u_front (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .full      (full),
      .req_data  (req_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_data  (csr_data),
      .cmd_full  (cmd_full),
      .cmd_push  (cmd_push),
      .cmd_data  (cmd_wr)
   );

   // Command queue.
   sle_cmd_fifo u_cmd_fifo (
      .clock    (clock),
      .reset    (reset),
      .wr_en    (cmd_push),
      .wr_data  (cmd_wr),
      .full_out (cmd_full),
      .rd_en    (cmd_pop),
      .rd_valid (cmd_valid),
      .rd_data  (cmd_rd)
   );

   // Back part.
   sle_back u_back (
      .clock     (clock),
      .reset     (reset),
      .cmd_valid (cmd_valid),
      .cmd_data  (cmd_rd),
      .cmd_pop   (cmd_pop),
      .empty     (empty),
      .pop       (pop),
      .rsp_data  (rsp_data)
   );

endmodule
